### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge of aclk, off while in reset.
`define DEBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge of aclk, off while in reset.
`define DEBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/debs_pkg.sv
// ----------------------------------------------------------------------------
// debs_pkg
// Types, register indexes and reset constants of the drive enable and brake
// sequencer.
// ----------------------------------------------------------------------------
package debs_pkg;

    localparam int CFG_W   = 24;
    localparam int BLINK_W = 24;
    localparam int TDATA_W = 16;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_ENABLE_TIMEOUT = 2'd0;
    localparam cfg_index_t CFG_BRAKE_APPLY    = 2'd1;
    localparam cfg_index_t CFG_SLOW_BLINK     = 2'd2;
    localparam cfg_index_t CFG_FAST_BLINK     = 2'd3;

    localparam logic [CFG_W-1:0] DEF_ENABLE_TIMEOUT = 24'd1000;
    localparam logic [CFG_W-1:0] DEF_BRAKE_APPLY    = 24'd500;
    localparam logic [CFG_W-1:0] DEF_SLOW_BLINK     = 24'd250;
    localparam logic [CFG_W-1:0] DEF_FAST_BLINK     = 24'd100;

    typedef enum logic [5:0] {
        ST_OFFLINE   = 6'b000001,
        ST_NOT_READY = 6'b000010,
        ST_READY     = 6'b000100,
        ST_ENABLING  = 6'b001000,
        ST_ENABLED   = 6'b010000,
        ST_DISABLING = 6'b100000
    } state_t;

    typedef logic [2:0] state_code_t;

    localparam state_code_t CODE_OFFLINE   = 3'd0;
    localparam state_code_t CODE_NOT_READY = 3'd1;
    localparam state_code_t CODE_READY     = 3'd2;
    localparam state_code_t CODE_ENABLING  = 3'd3;
    localparam state_code_t CODE_ENABLED   = 3'd4;
    localparam state_code_t CODE_DISABLING = 3'd5;

    // Input beat, first field in the highest bit.
    typedef struct packed {
        logic disable_request;
        logic enable_request;
        logic enable_switch;
        logic brake_overridden;
        logic brakes_open;
        logic all_axes_fault_free;
        logic any_axis_estop;
        logic all_axes_enabled;
        logic all_axes_ready;
        logic all_axes_online;
    } in_item_t;

    // Result beat, first field in the highest bit.
    typedef struct packed {
        logic        estop_active;
        logic        enabled_flag;
        logic        enabled_led;
        logic        error_led;
        logic        brake_release;
        logic        disable_axes;
        logic        enable_axes;
        state_code_t machine_state;
    } out_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

    function automatic state_code_t state_code(input state_t st);
        state_code_t code;
        case (st)
            ST_OFFLINE:   code = CODE_OFFLINE;
            ST_NOT_READY: code = CODE_NOT_READY;
            ST_READY:     code = CODE_READY;
            ST_ENABLING:  code = CODE_ENABLING;
            ST_ENABLED:   code = CODE_ENABLED;
            ST_DISABLING: code = CODE_DISABLING;
            default:      code = CODE_OFFLINE;
        endcase
        return code;
    endfunction

endpackage

### sv/debs_blink.sv
// ----------------------------------------------------------------------------
// debs_blink
// Tick-driven blink generator: counts ticks up to the half period, then
// clears and toggles its level.
// ----------------------------------------------------------------------------
module debs_blink
    import debs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic [BLINK_W-1:0] half_ticks,
    output logic               level_next
);

    logic [BLINK_W-1:0] count_reg;
    logic [BLINK_W-1:0] count_next;
    logic               level_reg;
    logic [BLINK_W-1:0] half_eff;
    logic [BLINK_W-1:0] count_inc;

    always_comb begin
        // a half period of zero behaves as one
        half_eff  = (half_ticks == '0) ? BLINK_W'(1) : half_ticks;
        count_inc = count_reg + BLINK_W'(1);
        if (count_inc >= half_eff) begin
            count_next = '0;
            level_next = ~level_reg;
        end else begin
            count_next = count_inc;
            level_next = level_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end else if (advance) begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

### sv/debs_seq.sv
// ----------------------------------------------------------------------------
// debs_seq
// Enable state machine, elapsed tick timers, pulse, brake and LED decode for
// one status beat.
// ----------------------------------------------------------------------------
module debs_seq
    import debs_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  in_item_t         item,
    input  logic [CFG_W-1:0] enable_timeout_ticks,
    input  logic [CFG_W-1:0] brake_apply_ticks,
    input  logic             slow_level,
    input  logic             fast_level,
    output out_item_t        result
);

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    state_t                state_reg;
    state_t                state_next;
    logic [TIMER_BITS-1:0] tsd_reg;
    logic [TIMER_BITS-1:0] tsd_next;
    logic [TIMER_BITS-1:0] tsd_inc;
    logic [TIMER_BITS-1:0] tser_reg;
    logic [TIMER_BITS-1:0] tser_next;
    logic [TIMER_BITS-1:0] tser_inc;
    logic                  en_pulse;
    logic                  dis_pulse;
    logic                  estop_on;
    logic                  close_brakes;
    logic                  err_led;
    logic                  en_led;
    logic                  timed_out;

    always_comb begin
        tsd_inc   = (tsd_reg == TMAX) ? tsd_reg : tsd_reg + TIMER_BITS'(1);
        tser_inc  = (tser_reg == TMAX) ? tser_reg : tser_reg + TIMER_BITS'(1);
        timed_out = CW'(tser_inc) > CW'(enable_timeout_ticks);
        estop_on  = item.all_axes_online & item.any_axis_estop;

        tsd_next   = tsd_inc;
        tser_next  = tser_inc;
        state_next = state_reg;
        en_pulse   = 1'b0;
        dis_pulse  = 1'b0;

        // override while enabled: drop the axes and restart the brake delay
        if (state_reg == ST_ENABLED && item.brake_overridden) begin
            tsd_next  = '0;
            dis_pulse = 1'b1;
        end

        if (item.all_axes_enabled && item.brakes_open && !item.brake_overridden) begin
            if (item.disable_request) begin
                dis_pulse  = 1'b1;
                tsd_next   = '0;
                state_next = ST_DISABLING;
            end else begin
                state_next = ST_ENABLED;
            end
        end else if (item.all_axes_ready && !item.brake_overridden) begin
            if (state_reg == ST_ENABLED) begin
                tsd_next = '0;
            end
            if (state_reg != ST_ENABLING && (item.enable_switch || item.enable_request)) begin
                tser_next  = '0;
                en_pulse   = 1'b1;
                state_next = ST_ENABLING;
            end else if (state_reg == ST_ENABLING) begin
                if (timed_out) begin
                    dis_pulse  = 1'b1;
                    state_next = ST_READY;
                end
            end else begin
                state_next = ST_READY;
            end
        end else begin
            if (state_reg == ST_ENABLED || state_reg == ST_ENABLING) begin
                tsd_next = '0;
            end
            state_next = item.all_axes_online ? ST_NOT_READY : ST_OFFLINE;
        end

        close_brakes = state_next != ST_ENABLED && state_next != ST_ENABLING &&
                       CW'(tsd_next) > CW'(brake_apply_ticks);

        if (estop_on) begin
            err_led = 1'b1;
        end else if (!item.all_axes_fault_free) begin
            err_led = slow_level;
        end else if (state_next == ST_NOT_READY) begin
            err_led = fast_level;
        end else begin
            err_led = 1'b0;
        end

        if (state_next == ST_ENABLED) begin
            en_led = 1'b1;
        end else if (state_next == ST_READY) begin
            en_led = slow_level;
        end else begin
            en_led = 1'b0;
        end

        result.machine_state = state_code(state_next);
        result.enable_axes   = en_pulse;
        result.disable_axes  = dis_pulse;
        result.brake_release = ~close_brakes;
        result.error_led     = err_led;
        result.enabled_led   = en_led;
        result.enabled_flag  = (state_next == ST_ENABLED);
        result.estop_active  = estop_on;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_OFFLINE;
            tsd_reg   <= TMAX;
            tser_reg  <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            tsd_reg   <= tsd_next;
            tser_reg  <= tser_next;
        end
    end

endmodule

### sv/drive_enable_brake_sequencer_unit.sv
// ----------------------------------------------------------------------------
// drive_enable_brake_sequencer_unit
// Per-tick drive enable state machine with brake delay and status LEDs.
// ----------------------------------------------------------------------------
// One status beat per fieldbus tick goes in, one result beat comes out. A beat
// is captured in an input register and evaluated by the state machine, timer
// and blink logic into the result register, so the block takes a new beat
// every clock while results keep flowing; m_tvalid rises when the evaluated
// beat is written into the result register. Write the four tick registers
// only while no beat is in flight.
module drive_enable_brake_sequencer_unit
    import debs_pkg::*;
#(
    parameter int TIMER_BITS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [0] all_axes_online [1] all_axes_ready [2] all_axes_enabled
    // [3] any_axis_estop [4] all_axes_fault_free [5] brakes_open
    // [6] brake_overridden [7] enable_switch [8] enable_request
    // [9] disable_request, [15:10] zero
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [2:0] machine_state [3] enable_axes [4] disable_axes [5] brake_release
    // [6] error_led [7] enabled_led [8] enabled_flag [9] estop_active,
    // [15:10] zero
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_wr_en,
    input  cfg_index_t         cfg_wr_index,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic             advance;
    out_item_t        result;
    logic             slow_level;
    logic             fast_level;
    logic [CFG_W-1:0] enable_timeout_reg;
    logic [CFG_W-1:0] brake_apply_reg;
    logic [CFG_W-1:0] slow_half_reg;
    logic [CFG_W-1:0] fast_half_reg;

    // evaluate the held beat once the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - OUT_W){1'b0}}, out_item_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_timeout_reg <= DEF_ENABLE_TIMEOUT;
            brake_apply_reg    <= DEF_BRAKE_APPLY;
            slow_half_reg      <= DEF_SLOW_BLINK;
            fast_half_reg      <= DEF_FAST_BLINK;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ENABLE_TIMEOUT: enable_timeout_reg <= cfg_wr_data;
                CFG_BRAKE_APPLY:    brake_apply_reg    <= cfg_wr_data;
                CFG_SLOW_BLINK:     slow_half_reg      <= cfg_wr_data;
                CFG_FAST_BLINK:     fast_half_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_t'(s_tdata[IN_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    debs_blink u_slow_blink (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .half_ticks (slow_half_reg),
        .level_next (slow_level)
    );

    debs_blink u_fast_blink (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .half_ticks (fast_half_reg),
        .level_next (fast_level)
    );

    debs_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .advance              (advance),
        .item                 (in_item_reg),
        .enable_timeout_ticks (enable_timeout_reg),
        .brake_apply_ticks    (brake_apply_reg),
        .slow_level           (slow_level),
        .fast_level           (fast_level),
        .result               (result)
    );

endmodule

### sv/debs_checker.sv
// ----------------------------------------------------------------------------
// debs_checker
// Port-level checks of the result stream of the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module debs_checker
    import debs_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    out_item_t res;

    assign res = out_item_t'(m_tdata[OUT_W-1:0]);

    // hold a stalled result beat
    `DEBS_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `DEBS_ASSERT_IMP(a_pulse_exclusive, m_tvalid, !(res.enable_axes && res.disable_axes), "enable and disable pulse in one beat")

    `DEBS_ASSERT_IMP(a_enable_pulse_state, m_tvalid && res.enable_axes, res.machine_state == CODE_ENABLING, "enable pulse outside enabling")

    `DEBS_ASSERT_IMP(a_enabled_brakes, m_tvalid && res.enabled_flag, res.brake_release && res.enabled_led && res.machine_state == CODE_ENABLED, "enabled beat inconsistent")

endmodule

bind drive_enable_brake_sequencer_unit debs_checker u_debs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
